>>> design/ridec_pkg.sv
// ----------------------------------------------------------------------------
// ridec_pkg
// shared types and codes of the instruction decoder
// ----------------------------------------------------------------------------
`default_nettype none

package ridec_pkg;

	localparam int unsigned WordW   = 32;
	localparam int unsigned RegW    = 5;
	localparam int unsigned ImmW    = 16;
	localparam int unsigned IdxW    = 26;
	localparam int unsigned OpW     = 6;
	localparam int unsigned OutDataW = 136;

	localparam logic [WordW-1:0] PcStep = 32'd4;

	// dense mnemonic codes
	typedef enum logic [4:0] {
		MN_HALT = 5'd0,
		MN_ADD, MN_SUB, MN_AND, MN_OR, MN_XOR, MN_NOR, MN_NAND, MN_SLT,
		MN_SLL, MN_SRL, MN_SRA, MN_JR,
		MN_JAL, MN_J,
		MN_ADDI, MN_LW, MN_LH, MN_LHU, MN_LB, MN_LBU, MN_SW, MN_SH, MN_SB,
		MN_LUI, MN_ANDI, MN_ORI, MN_NORI, MN_SLTI, MN_BEQ, MN_BNE,
		MN_UNKNOWN
	} mnemonic_t;

	// opcode field codes
	localparam logic [OpW-1:0] OP_RTYPE = 6'h00;
	localparam logic [OpW-1:0] OP_J     = 6'h02;
	localparam logic [OpW-1:0] OP_JAL   = 6'h03;
	localparam logic [OpW-1:0] OP_BEQ   = 6'h04;
	localparam logic [OpW-1:0] OP_BNE   = 6'h05;
	localparam logic [OpW-1:0] OP_ADDI  = 6'h08;
	localparam logic [OpW-1:0] OP_SLTI  = 6'h0A;
	localparam logic [OpW-1:0] OP_ANDI  = 6'h0C;
	localparam logic [OpW-1:0] OP_ORI   = 6'h0D;
	localparam logic [OpW-1:0] OP_NORI  = 6'h0E;
	localparam logic [OpW-1:0] OP_LUI   = 6'h0F;
	localparam logic [OpW-1:0] OP_LB    = 6'h20;
	localparam logic [OpW-1:0] OP_LH    = 6'h21;
	localparam logic [OpW-1:0] OP_LW    = 6'h23;
	localparam logic [OpW-1:0] OP_LBU   = 6'h24;
	localparam logic [OpW-1:0] OP_LHU   = 6'h25;
	localparam logic [OpW-1:0] OP_SB    = 6'h28;
	localparam logic [OpW-1:0] OP_SH    = 6'h29;
	localparam logic [OpW-1:0] OP_SW    = 6'h2B;
	localparam logic [OpW-1:0] OP_HALT  = 6'h3F;

	// function field codes of r-type words
	localparam logic [OpW-1:0] FN_SLL  = 6'h00;
	localparam logic [OpW-1:0] FN_SRL  = 6'h02;
	localparam logic [OpW-1:0] FN_SRA  = 6'h03;
	localparam logic [OpW-1:0] FN_JR   = 6'h08;
	localparam logic [OpW-1:0] FN_ADD  = 6'h20;
	localparam logic [OpW-1:0] FN_SUB  = 6'h22;
	localparam logic [OpW-1:0] FN_AND  = 6'h24;
	localparam logic [OpW-1:0] FN_OR   = 6'h25;
	localparam logic [OpW-1:0] FN_XOR  = 6'h26;
	localparam logic [OpW-1:0] FN_NOR  = 6'h27;
	localparam logic [OpW-1:0] FN_NAND = 6'h28;
	localparam logic [OpW-1:0] FN_SLT  = 6'h2A;

	// fetched word with its address
	typedef struct packed {
		logic [WordW-1:0] addr;
		logic [WordW-1:0] word;
	} fetch_t;

	// decoded item, first field in the high bits
	typedef struct packed {
		logic [WordW-1:0]       instr_addr;
		logic [WordW-1:0]       jump_target;
		logic [IdxW-1:0]        jump_index;
		logic signed [ImmW-1:0] immediate;
		logic [RegW-1:0]        shift_amount;
		logic [RegW-1:0]        dst_reg;
		logic [RegW-1:0]        tgt_reg;
		logic [RegW-1:0]        src_reg;
		logic                   known;
		mnemonic_t              mnemonic;
	} result_t;

endpackage

`default_nettype wire

>>> design/ridec_fetch.sv
// ----------------------------------------------------------------------------
// ridec_fetch
// program counter and input register stage
// ----------------------------------------------------------------------------
`default_nettype none

module ridec_fetch (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_wen,
	input  wire  [ridec_pkg::WordW-1:0]   cfg_wdata,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [ridec_pkg::WordW-1:0]   in_word,
	input  wire                           take,
	output logic                          valid_s1,
	output ridec_pkg::fetch_t             item_s1
);
	import ridec_pkg::*;

	logic [WordW-1:0] pc_q;
	logic             accept;

	assign in_ready = !valid_s1 || take;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_wen) begin
				pc_q <= cfg_wdata;
			end else if (accept) begin
				pc_q <= pc_q + PcStep;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.word <= in_word;
			item_s1.addr <= pc_q;
		end
	end

endmodule

`default_nettype wire

>>> design/ridec_decode.sv
// ----------------------------------------------------------------------------
// ridec_decode
// combinational classification and field extraction of one word
// ----------------------------------------------------------------------------
`default_nettype none

module ridec_decode (
	input  ridec_pkg::fetch_t  item,
	output ridec_pkg::result_t res
);
	import ridec_pkg::*;

	logic [OpW-1:0]   op;
	logic [OpW-1:0]   fn;
	logic [WordW-1:0] next_pc;
	mnemonic_t        mn;
	mnemonic_t        r_mn;

	assign op      = item.word[31:26];
	assign fn      = item.word[5:0];
	assign next_pc = item.addr + PcStep;

	always_comb begin
		case (fn)
			FN_ADD:  r_mn = MN_ADD;
			FN_SUB:  r_mn = MN_SUB;
			FN_AND:  r_mn = MN_AND;
			FN_OR:   r_mn = MN_OR;
			FN_XOR:  r_mn = MN_XOR;
			FN_NOR:  r_mn = MN_NOR;
			FN_NAND: r_mn = MN_NAND;
			FN_SLT:  r_mn = MN_SLT;
			FN_SLL:  r_mn = MN_SLL;
			FN_SRL:  r_mn = MN_SRL;
			FN_SRA:  r_mn = MN_SRA;
			FN_JR:   r_mn = MN_JR;
			default: r_mn = MN_UNKNOWN;
		endcase
	end

	always_comb begin
		case (op)
			OP_HALT:  mn = MN_HALT;
			OP_RTYPE: mn = r_mn;
			OP_JAL:   mn = MN_JAL;
			OP_J:     mn = MN_J;
			OP_ADDI:  mn = MN_ADDI;
			OP_LW:    mn = MN_LW;
			OP_LH:    mn = MN_LH;
			OP_LHU:   mn = MN_LHU;
			OP_LB:    mn = MN_LB;
			OP_LBU:   mn = MN_LBU;
			OP_SW:    mn = MN_SW;
			OP_SH:    mn = MN_SH;
			OP_SB:    mn = MN_SB;
			OP_LUI:   mn = MN_LUI;
			OP_ANDI:  mn = MN_ANDI;
			OP_ORI:   mn = MN_ORI;
			OP_NORI:  mn = MN_NORI;
			OP_SLTI:  mn = MN_SLTI;
			OP_BEQ:   mn = MN_BEQ;
			OP_BNE:   mn = MN_BNE;
			default:  mn = MN_UNKNOWN;
		endcase
	end

	always_comb begin
		res.mnemonic     = mn;
		res.known        = (mn != MN_UNKNOWN);
		res.src_reg      = item.word[25:21];
		res.tgt_reg      = item.word[20:16];
		res.dst_reg      = item.word[15:11];
		res.shift_amount = item.word[10:6];
		res.immediate    = item.word[15:0];
		res.jump_index   = item.word[25:0];
		res.jump_target  = {next_pc[31:28], item.word[25:0], 2'b00};
		res.instr_addr   = item.addr;
	end

endmodule

`default_nettype wire

>>> design/risc_instruction_decoder_top.sv
// ----------------------------------------------------------------------------
// risc_instruction_decoder_top
// instruction decoder with running program counter, stream in and out
// ----------------------------------------------------------------------------
// a word is taken into the input register, decoded, and held in the result register
// one word per cycle while the output is not stalled, set by the input and output register stages
// a stalled output lets the input register take one more word, then tready drops
// reset clears the program counter and both stage valid flags
// a write of cfg_wdata loads the program counter with all 32 bits
`default_nettype none

module risc_instruction_decoder_top (
	input  wire                             clk,
	input  wire                             arst_n,
	// start address write
	input  wire                             cfg_wen,
	input  wire  [ridec_pkg::WordW-1:0]     cfg_wdata,
	// instruction words in
	input  wire                             s_axis_tvalid,
	output logic                            s_axis_tready,
	input  wire  [ridec_pkg::WordW-1:0]     s_axis_tdata,  // instr_word
	// decoded items out
	output logic                            m_axis_tvalid,
	input  wire                             m_axis_tready,
	// mnemonic, known, src_reg, tgt_reg, dst_reg, shift_amount, immediate,
	// jump_index, jump_target, instr_addr, zero pad
	output logic [ridec_pkg::OutDataW-1:0]  m_axis_tdata
);
	import ridec_pkg::*;

	localparam int unsigned PadW = OutDataW - $bits(result_t);

	fetch_t  item_s1;
	result_t dec;
	result_t res_s2;
	logic    valid_s1;
	logic    take_s1;

	// output register can load when empty or when its item transfers now
	assign take_s1 = !m_axis_tvalid || m_axis_tready;

	// input register and program counter
	ridec_fetch u_fetch (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_word   (s_axis_tdata),
		.take      (take_s1),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	// decode between the two registers
	ridec_decode u_decode (
		.item (item_s1),
		.res  (dec)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (take_s1) begin
			m_axis_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && valid_s1) begin
			res_s2 <= dec;
		end
	end

	assign m_axis_tdata = {{PadW{1'b0}}, res_s2};

endmodule

`default_nettype wire

>>> design/ridec_checker.sv
// ----------------------------------------------------------------------------
// ridec_checker
// port-level checks of the instruction decoder
// ----------------------------------------------------------------------------
`default_nettype none

module ridec_checker (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             s_axis_tready,
	input wire                             m_axis_tvalid,
	input wire                             m_axis_tready,
	input wire [ridec_pkg::OutDataW-1:0]   m_axis_tdata
);
	import ridec_pkg::*;

	logic [WordW-1:0] next_addr;

	assign next_addr = m_axis_tdata[131:100] + PcStep;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// known flag agrees with the mnemonic
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[5] == (m_axis_tdata[4:0] != MN_UNKNOWN)))
		else $error("known flag mismatch");

	// low part of jump target is the index shifted by two
	a_jlow: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[95:70] == m_axis_tdata[67:42])
			&& (m_axis_tdata[69:68] == 2'b00))
		else $error("jump target low bits wrong");

	// top of jump target comes from the following address
	a_jhigh: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[99:96] == next_addr[31:28]))
		else $error("jump target region wrong");

	// input only stalls behind a stalled result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output stall");

endmodule

bind risc_instruction_decoder_top ridec_checker u_ridec_checker (.*);

`default_nettype wire

>>> verif/decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decode_checker
// watches the word and result streams, predicts each decoded item and
// compares it field by field with what the decoder hands out
// ----------------------------------------------------------------------------

module decode_checker (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_wen,
	input  wire  [ridec_pkg::WordW-1:0]     cfg_wdata,
	input  wire                             s_axis_tvalid,
	input  wire                             s_axis_tready,
	input  wire  [ridec_pkg::WordW-1:0]     s_axis_tdata,
	input  wire                             m_axis_tvalid,
	input  wire                             m_axis_tready,
	input  wire  [ridec_pkg::OutDataW-1:0]  m_axis_tdata,
	output int unsigned                     errors,
	output int unsigned                     pending
);

	import ridec_pkg::*;

	localparam int unsigned ItemW = $bits(result_t);

	logic [WordW-1:0] fetch_pc = '0;
	result_t          decoded_q [$];

	initial begin
		errors  = 0;
		pending = 0;
	end

	// decode one word at the given address
	function automatic result_t decode_word(input logic [WordW-1:0] w, input logic [WordW-1:0] pc);
		result_t          r;
		logic [OpW-1:0]   op;
		logic [OpW-1:0]   fn;
		logic [WordW-1:0] nxt;
		op  = w[31:26];
		fn  = w[5:0];
		nxt = pc + PcStep;
		case (op)
			OP_HALT:  r.mnemonic = MN_HALT;
			OP_RTYPE: begin
				case (fn)
					FN_ADD:  r.mnemonic = MN_ADD;
					FN_SUB:  r.mnemonic = MN_SUB;
					FN_AND:  r.mnemonic = MN_AND;
					FN_OR:   r.mnemonic = MN_OR;
					FN_XOR:  r.mnemonic = MN_XOR;
					FN_NOR:  r.mnemonic = MN_NOR;
					FN_NAND: r.mnemonic = MN_NAND;
					FN_SLT:  r.mnemonic = MN_SLT;
					FN_SLL:  r.mnemonic = MN_SLL;
					FN_SRL:  r.mnemonic = MN_SRL;
					FN_SRA:  r.mnemonic = MN_SRA;
					FN_JR:   r.mnemonic = MN_JR;
					default: r.mnemonic = MN_UNKNOWN;
				endcase
			end
			OP_JAL:   r.mnemonic = MN_JAL;
			OP_J:     r.mnemonic = MN_J;
			OP_ADDI:  r.mnemonic = MN_ADDI;
			OP_LW:    r.mnemonic = MN_LW;
			OP_LH:    r.mnemonic = MN_LH;
			OP_LHU:   r.mnemonic = MN_LHU;
			OP_LB:    r.mnemonic = MN_LB;
			OP_LBU:   r.mnemonic = MN_LBU;
			OP_SW:    r.mnemonic = MN_SW;
			OP_SH:    r.mnemonic = MN_SH;
			OP_SB:    r.mnemonic = MN_SB;
			OP_LUI:   r.mnemonic = MN_LUI;
			OP_ANDI:  r.mnemonic = MN_ANDI;
			OP_ORI:   r.mnemonic = MN_ORI;
			OP_NORI:  r.mnemonic = MN_NORI;
			OP_SLTI:  r.mnemonic = MN_SLTI;
			OP_BEQ:   r.mnemonic = MN_BEQ;
			OP_BNE:   r.mnemonic = MN_BNE;
			default:  r.mnemonic = MN_UNKNOWN;
		endcase
		r.known        = (r.mnemonic != MN_UNKNOWN);
		r.src_reg      = w[25:21];
		r.tgt_reg      = w[20:16];
		r.dst_reg      = w[15:11];
		r.shift_amount = w[10:6];
		r.immediate    = w[15:0];
		r.jump_index   = w[25:0];
		// region bits come from the address after this word
		r.jump_target  = {nxt[31:28], w[25:0], 2'b00};
		r.instr_addr   = pc;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			fetch_pc = '0;
			decoded_q.delete();
		end else begin
			// only written while idle, so never in the cycle of a word transfer
			if (cfg_wen)
				fetch_pc = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready) begin
				decoded_q.push_back(decode_word(s_axis_tdata, fetch_pc));
				fetch_pc = fetch_pc + PcStep;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata[ItemW-1:0]);
				if (decoded_q.size() == 0) begin
					errors++;
					$display("%0t ns: result with nothing expected, expected none, actual 0x%0h",
						$time, m_axis_tdata);
				end else begin
					want = decoded_q.pop_front();
					check_field("mnemonic", 32'(want.mnemonic), 32'(got.mnemonic));
					check_field("known", 32'(want.known), 32'(got.known));
					check_field("src_reg", 32'(want.src_reg), 32'(got.src_reg));
					check_field("tgt_reg", 32'(want.tgt_reg), 32'(got.tgt_reg));
					check_field("dst_reg", 32'(want.dst_reg), 32'(got.dst_reg));
					check_field("shift_amount", 32'(want.shift_amount),
						32'(got.shift_amount));
					check_field("immediate", 32'(want.immediate), 32'(got.immediate));
					check_field("jump_index", 32'(want.jump_index), 32'(got.jump_index));
					check_field("jump_target", want.jump_target, got.jump_target);
					check_field("instr_addr", want.instr_addr, got.instr_addr);
					check_field("pad", '0, 32'(m_axis_tdata[OutDataW-1:ItemW]));
				end
			end
		end
		pending = decoded_q.size();
	end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the instruction decoder: directed words for every mnemonic
// and field extreme, then random phases at several start addresses and
// idle profiles, checked by decode_checker
// ----------------------------------------------------------------------------

module tb;

	import ridec_pkg::*;

	// timing of the run
	localparam int unsigned HalfPeriod     = 5;
	localparam int unsigned ResetCycles    = 10;
	localparam int unsigned DrainCycles    = 8;     // margin past the two-stage latency
	localparam int unsigned HoldCycles     = 400;   // long output hold-off
	localparam int unsigned WatchdogLimit  = 3000;  // cycles with no transfer and no start address write
	localparam int unsigned PhaseItems     = 150;
	localparam int unsigned NumPhases      = 6;

	// opcode and function values that decode to nothing
	localparam logic [OpW-1:0] OP_UNUSED = 6'h3E;
	localparam logic [OpW-1:0] FN_UNUSED = 6'h01;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_wen       = 1'b0;
	logic [WordW-1:0]     cfg_wdata     = '0;
	logic                 s_axis_tvalid = 1'b0;
	wire                  s_axis_tready;
	logic [WordW-1:0]     s_axis_tdata  = '0;
	wire                  m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	wire  [OutDataW-1:0]  m_axis_tdata;

	int unsigned errors;
	int unsigned pending;

	// idle profile, percent of cycles
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	// long hold-off request, raised by the stimulus and dropped by the receiver
	logic        hold_req = 1'b0;
	int unsigned hold_count = 0;
	int unsigned quiet_cycles = 0;

	// function codes in mnemonic order add..jr
	logic [OpW-1:0] rtype_fn [0:11] = '{FN_ADD, FN_SUB, FN_AND, FN_OR, FN_XOR, FN_NOR,
		FN_NAND, FN_SLT, FN_SLL, FN_SRL, FN_SRA, FN_JR};
	// opcodes in mnemonic order addi..bne
	logic [OpW-1:0] itype_op [0:15] = '{OP_ADDI, OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU,
		OP_SW, OP_SH, OP_SB, OP_LUI, OP_ANDI, OP_ORI, OP_NORI, OP_SLTI, OP_BEQ, OP_BNE};

	risc_instruction_decoder_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // instr_word
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)    // mnemonic up to instr_addr, zero pad on top
	);

	decode_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.errors        (errors),
		.pending       (pending)
	);

	always #(HalfPeriod) clk = ~clk;

	// receiver: random stalls, or a long hold-off counted here
	always @(negedge clk) begin
		if (hold_req) begin
			m_axis_tready <= 1'b0;
			hold_count++;
			if (hold_count >= HoldCycles) begin
				hold_count = 0;
				hold_req <= 1'b0;
			end
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wen) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WatchdogLimit) begin
					$display("Simulation FAILED");
					$finish;
				end
			end
		end
	end

	// word for a known mnemonic: index 0..11 r-type, 12 j, 13 jal, 14..29 i-type
	function automatic logic [WordW-1:0] encode_known(input int unsigned k, input logic [25:0] low);
		if (k < 12)
			return {OP_RTYPE, low[25:6], rtype_fn[k]};
		else if (k == 12)
			return {OP_J, low};
		else if (k == 13)
			return {OP_JAL, low};
		else
			return {itype_op[k-14], low};
	endfunction

	// mostly well-formed words with random fields, some halts, noise and odd r-types
	function automatic logic [WordW-1:0] random_word();
		logic [25:0] low;
		low = 26'($urandom());
		case ($urandom_range(9))
			0:       return $urandom();
			1:       return {OP_RTYPE, low[25:6], 6'($urandom())};
			2:       return {OP_HALT, low};
			default: return encode_known($urandom_range(29), low);
		endcase
	endfunction

	// one word transfer; called and left at a falling edge
	task automatic send_word(input logic [WordW-1:0] w);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= w;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// stop offering and wait until every decoded item has come out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic write_start_pc(input logic [WordW-1:0] v);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wen   <= 1'b0;
	endtask

	initial begin
		logic [WordW-1:0] start_addrs [0:NumPhases-1];
		logic [25:0]      pattern;

		// zero, early wrap, unaligned, random, all ones, top aligned
		start_addrs = '{32'h0000_0000, 32'hffff_fff0, 32'h0000_0003, $urandom(),
			32'hffff_ffff, 32'hffff_fffc};

		repeat (ResetCycles) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed words at the reset address, no idling
		send_word(32'h0000_0000);                 // sll with every field zero
		send_word(32'hffff_ffff);                 // halt with every field at its top
		send_word({OP_HALT, 26'h0});
		for (int k = 0; k < 12; k++) begin
			// alternate field extremes: rs/rd high or rt/shamt high
			pattern = (k % 2) ? 26'b00000_11111_00000_11111_000000 :
				26'b11111_00000_11111_00000_000000;
			send_word(encode_known(k, pattern));
		end
		send_word(encode_known(12, 26'h3ff_ffff));
		send_word(encode_known(13, 26'h000_0000));
		for (int k = 14; k < 30; k++) begin
			// immediate at its most negative, then its most positive
			pattern = (k % 2) ? 26'h3ff_7fff : 26'h000_8000;
			send_word(encode_known(k, pattern));
		end
		send_word({OP_UNUSED, 26'h155_5555});
		send_word({OP_RTYPE, 20'haaaaa, FN_UNUSED});
		drain();

		// random phases, each from its own start address and idle profile
		for (int p = 0; p < NumPhases; p++) begin
			write_start_pc(start_addrs[p]);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			for (int i = 0; i < PhaseItems; i++) begin
				// output held off while words keep coming, so the input backs up
				if (p == 4 && i == 20)
					hold_req <= 1'b1;
				// sender waits for the pipe to empty mid-stream
				if (p == 5 && i == 75)
					drain();
				send_word(random_word());
			end
			drain();
		end

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> filelist.f
design/ridec_pkg.sv
design/ridec_fetch.sv
design/ridec_decode.sv
design/risc_instruction_decoder_top.sv
design/ridec_checker.sv
verif/decode_checker.sv
verif/tb.sv
